>>> sv/integer_to_radix_text_core_macros.svh
// Assertion macros shared by the radix text core.
// No dependencies; taken in by the files that check their own logic.
`ifndef INTEGER_TO_RADIX_TEXT_CORE_MACROS_SVH
`define INTEGER_TO_RADIX_TEXT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ITRT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itrt check failed");
// Next-cycle implication, disabled during reset.
`define ITRT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itrt check failed");
`else
`define ITRT_ASSERT_NOW(label, clk, rst, ante, cons)
`define ITRT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/itrt_pkg.sv
// Types, constants and the digit-to-character function of the radix text core.
// No dependencies.
`default_nettype none

package itrt_pkg;

   localparam int NUMBER_W = 32;
   localparam int RADIX_W  = 6;
   localparam int CHAR_W   = 7;

   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] DIGIT_TEN = 6'd10;

   localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;

   // Classified job as it passes from front to back
   typedef struct packed {
      logic                negative;
      logic                upper;
      logic [RADIX_W-1:0]  radix;
   } job_ctrl_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] base_char;
      if (d < DIGIT_TEN) begin
         return CHAR_ZERO + CHAR_W'(d);
      end
      base_char = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
      return base_char + CHAR_W'(d - DIGIT_TEN);
   endfunction

endpackage

`default_nettype wire

>>> sv/itrt_channels.sv
// Request and response channel interfaces of the radix text core.
// Depends on itrt_pkg for field widths.
`default_nettype none

interface itrt_req_if;
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic [itrt_pkg::NUMBER_W-1:0] number;
   logic [itrt_pkg::RADIX_W-1:0]  radix;
   logic                         upper_letters;

   modport source (output valid, req_type, number, radix, upper_letters, input ready);
   modport sink   (input valid, req_type, number, radix, upper_letters, output ready);
endinterface

interface itrt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [itrt_pkg::CHAR_W-1:0] text_char;
   logic                        last_char;

   modport source (output valid, text_char, last_char, input ready);
   modport sink   (input valid, text_char, last_char, output ready);
endinterface

`default_nettype wire

>>> sv/itrt_front.sv
// Front end: takes requests, clamps the radix, splits sign and magnitude.
// Depends on itrt_pkg and itrt_channels.
`default_nettype none

module itrt_front #(
   parameter int VALUE_WIDTH = 32
) (
   itrt_req_if.sink                 req,
   output logic                     job_valid,
   input  logic                     job_ready,
   output itrt_pkg::job_ctrl_type   job_ctrl,
   output logic [VALUE_WIDTH-1:0]   job_mag
);

   logic [VALUE_WIDTH-1:0] value;
   logic                   negative;

   assign value    = VALUE_WIDTH'(req.number);
   assign negative = req.req_type & value[VALUE_WIDTH-1];

   always_comb begin
      job_ctrl.negative = negative;
      job_ctrl.upper    = req.upper_letters;
      priority if (req.radix < itrt_pkg::RADIX_MIN) begin
         job_ctrl.radix = itrt_pkg::RADIX_MIN;
      end else if (req.radix > itrt_pkg::RADIX_MAX) begin
         job_ctrl.radix = itrt_pkg::RADIX_MAX;
      end else begin
         job_ctrl.radix = req.radix;
      end
   end

   // most negative value wraps onto its own magnitude
   assign job_mag   = negative ? (VALUE_WIDTH'(0) - value) : value;
   assign job_valid = req.valid;
   assign req.ready = job_ready;

endmodule

`default_nettype wire

>>> sv/itrt_queue.sv
// Two-entry job queue between front and back end.
// No package dependencies.
`default_nettype none

module itrt_queue #(
   parameter int DATA_W = 40
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/itrt_back.sv
// Back end: bit-serial divider that peels off digits, digit memory,
// and the character sequencer with its output register.
// Depends on itrt_pkg, itrt_channels and the assertion macro header.
`default_nettype none
`include "integer_to_radix_text_core_macros.svh"

module itrt_back #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  itrt_pkg::job_ctrl_type job_ctrl,
   input  logic [VALUE_WIDTH-1:0] job_mag,
   itrt_rsp_if.source             rsp
);

   localparam int IDX_W = $clog2(VALUE_WIDTH);
   localparam int RW    = itrt_pkg::RADIX_W;
   localparam int CW    = itrt_pkg::CHAR_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SIGN,
      ST_WAIT,
      ST_SEND
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [RW-1:0]          radix_ff, radix_in;
   logic                   upper_ff, upper_in;
   logic                   neg_ff, neg_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic [IDX_W-1:0]       bit_cnt_ff, bit_cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic [CW-1:0]          out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;

   logic [RW-1:0]          digit_mem [VALUE_WIDTH];
   logic [RW-1:0]          rd_data_ff;
   logic                   mem_we;

   logic [RW:0]            shifted;
   logic                   ge;
   logic [RW-1:0]          rem_next;
   logic [VALUE_WIDTH-1:0] quo_next;
   logic                   out_free;
   logic                   job_pop;

   // one restoring division step
   always_comb begin
      shifted  = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      ge       = (shifted >= {1'b0, radix_ff});
      rem_next = ge ? RW'(shifted - {1'b0, radix_ff}) : shifted[RW-1:0];
      quo_next = {quo_ff[VALUE_WIDTH-2:0], ge};
   end

   assign out_free  = !out_valid_ff || rsp.ready;
   assign job_ready = (state_ff == ST_IDLE);
   assign job_pop   = job_valid && job_ready;

   always_comb begin
      state_in     = state_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      radix_in     = radix_ff;
      upper_in     = upper_ff;
      neg_in       = neg_ff;
      idx_in       = idx_ff;
      bit_cnt_in   = bit_cnt_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      mem_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               quo_in     = job_mag;
               rem_in     = '0;
               radix_in   = job_ctrl.radix;
               upper_in   = job_ctrl.upper;
               neg_in     = job_ctrl.negative;
               idx_in     = '0;
               bit_cnt_in = IDX_W'(VALUE_WIDTH - 1);
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in = quo_next;
            rem_in = rem_next;
            if (bit_cnt_ff == '0) begin
               mem_we = 1'b1;
               rem_in = '0;
               if (quo_next != '0) begin
                  idx_in     = idx_ff + IDX_W'(1);
                  bit_cnt_in = IDX_W'(VALUE_WIDTH - 1);
               end else begin
                  state_in = neg_ff ? ST_SIGN : ST_WAIT;
               end
            end else begin
               bit_cnt_in = bit_cnt_ff - IDX_W'(1);
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = itrt_pkg::CHAR_MINUS;
               out_last_in  = 1'b0;
               state_in     = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = itrt_pkg::digit_char(rd_data_ff, upper_ff);
               out_last_in  = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff - IDX_W'(1);
                  state_in = ST_WAIT;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         quo_ff       <= '0;
         rem_ff       <= '0;
         neg_ff       <= 1'b0;
         idx_ff       <= '0;
         bit_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
         radix_ff     <= itrt_pkg::RADIX_MIN;
      end else begin
         state_ff     <= state_in;
         quo_ff       <= quo_in;
         rem_ff       <= rem_in;
         neg_ff       <= neg_in;
         idx_ff       <= idx_in;
         bit_cnt_ff   <= bit_cnt_in;
         out_valid_ff <= out_valid_in;
         radix_ff     <= radix_in;
      end
      upper_ff    <= upper_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   // digit memory, least significant digit at index zero
   always_ff @(posedge clock) begin
      if (mem_we) begin
         digit_mem[idx_ff] <= rem_next;
      end
      rd_data_ff <= digit_mem[idx_ff];
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.text_char = out_char_ff;
   assign rsp.last_char = out_last_ff;

   `ITRT_ASSERT_NOW(a_radix_range, clock, reset, state_ff == ST_DIV,
      radix_ff >= itrt_pkg::RADIX_MIN && radix_ff <= itrt_pkg::RADIX_MAX)
   `ITRT_ASSERT_NOW(a_rem_below_radix, clock, reset, state_ff == ST_DIV, rem_ff < radix_ff)
   `ITRT_ASSERT_NEXT(a_pop_starts_div, clock, reset, job_pop, state_ff == ST_DIV)
   `ITRT_ASSERT_NOW(a_load_needs_room, clock, reset,
      (state_ff == ST_SEND || state_ff == ST_SIGN) && !out_free, state_in == state_ff)

endmodule

`default_nettype wire

>>> sv/integer_to_radix_text_core.sv
// Integer to radix text converter: front end, job queue and back end.
// Depends on itrt_pkg, itrt_channels, itrt_front, itrt_queue and itrt_back.
//
// Use:
//  - req carries one number per transaction: req_type (0 unsigned, 1 signed),
//    number, radix (clamped to 2..36) and upper_letters. A transaction completes
//    on a clock edge with valid and ready both high.
//  - rsp returns the ASCII text, most significant character first, one
//    character per transaction; last_char marks the final one. A negative
//    signed number starts with '-'; zero gives a single '0'.
//  - Each digit comes from a full division of the remaining quotient in the
//    shared one-bit-per-cycle divider; the sequencer then passes each character
//    through its wait and send states. The first character appears only
//    after the last digit has been computed.
//  - A two-entry queue holds waiting requests, so req keeps accepting while
//    the back end converts; one number is converted at a time.
//  - If the receiver stalls, the current character stays in the output
//    register and the sequencer waits; the queue fills, then req drops ready.
//  - Synchronous reset empties the queue and output register and idles the
//    back end; the digit memory needs no clearing.
`default_nettype none

module integer_to_radix_text_core #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   itrt_req_if.sink    req,
   itrt_rsp_if.source  rsp
);

   localparam int CTRL_W = $bits(itrt_pkg::job_ctrl_type);
   localparam int DATA_W = CTRL_W + VALUE_WIDTH;

   logic                   front_valid, front_ready;
   itrt_pkg::job_ctrl_type front_ctrl;
   logic [VALUE_WIDTH-1:0] front_mag;

   logic                   back_valid, back_ready;
   itrt_pkg::job_ctrl_type back_ctrl;
   logic [VALUE_WIDTH-1:0] back_mag;
   logic [DATA_W-1:0]      push_data, pop_data;

   itrt_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .req       (req),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_ctrl  (front_ctrl),
      .job_mag   (front_mag)
   );

   assign push_data = {front_ctrl, front_mag};

   itrt_queue #(.DATA_W(DATA_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (push_data),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (pop_data)
   );

   assign back_ctrl = pop_data[DATA_W-1:VALUE_WIDTH];
   assign back_mag  = pop_data[VALUE_WIDTH-1:0];

   itrt_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_ctrl  (back_ctrl),
      .job_mag   (back_mag),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire
